// File: sv/mld_pkg.sv
// Shared constants and types for the magic/length message deframer.
package mld_pkg;

    // Header layout
    localparam int unsigned LENGTH_BYTES = 4;
    localparam int unsigned LEN_IDX_W    = (LENGTH_BYTES > 1) ? $clog2(LENGTH_BYTES) : 1;
    localparam logic [LEN_IDX_W-1:0] LEN_IDX_LAST = LEN_IDX_W'(LENGTH_BYTES - 1);

    localparam int unsigned REMAIN_W = 32;

    // Magic byte register reset value (ASCII 'M')
    localparam logic [7:0] MAGIC_RESET = 8'd77;

    // Phase codes
    localparam logic [1:0] PH_HUNT = 2'd0;
    localparam logic [1:0] PH_LEN  = 2'd1;
    localparam logic [1:0] PH_DATA = 2'd2;

    // Result kinds
    localparam logic [1:0] KIND_DATA  = 2'd0;
    localparam logic [1:0] KIND_EMPTY = 2'd1;
    localparam logic [1:0] KIND_DROP  = 2'd2;

    // Register byte addresses
    localparam logic [2:0] ADDR_MAGIC = 3'd0;

    typedef struct packed {
        logic       valid;
        logic [1:0] kind;
        logic [7:0] data;
        logic       last;
    } mld_result_t;

endpackage

// File: sv/mld_core.sv
// Deframer state machine: phase, length gathering and payload countdown.
module mld_core
    import mld_pkg::*;
(
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        step,
    input  logic [7:0]  in_byte,
    input  logic [7:0]  magic_byte,
    output mld_result_t result
);

    logic [1:0]           phase_reg, phase_next;
    logic [LEN_IDX_W-1:0] idx_reg, idx_next;
    logic [REMAIN_W-1:0]  remain_reg, remain_next;
    logic [REMAIN_W-1:0]  len_shift;
    logic                 data_last;

    assign len_shift = {remain_reg[REMAIN_W-9:0], in_byte};
    assign data_last = (remain_reg <= REMAIN_W'(1));

    always_comb begin
        phase_next   = phase_reg;
        idx_next     = idx_reg;
        remain_next  = remain_reg;
        result       = '0;
        unique case (phase_reg)
            PH_LEN: begin
                remain_next = len_shift;
                idx_next    = idx_reg + LEN_IDX_W'(1);
                if (idx_reg == LEN_IDX_LAST) begin
                    idx_next = '0;
                    if (len_shift == '0) begin
                        phase_next   = PH_HUNT;
                        result.valid = 1'b1;
                        result.kind  = KIND_EMPTY;
                        result.last  = 1'b1;
                    end else begin
                        phase_next = PH_DATA;
                    end
                end
            end
            PH_DATA: begin
                result.valid = 1'b1;
                result.kind  = KIND_DATA;
                result.data  = in_byte;
                result.last  = data_last;
                if (data_last) begin
                    remain_next = '0;
                    phase_next  = PH_HUNT;
                end else begin
                    remain_next = remain_reg - REMAIN_W'(1);
                end
            end
            default: begin
                // hunt, and the unused code falls back to it
                phase_next = PH_HUNT;
                if (in_byte == magic_byte) begin
                    phase_next  = PH_LEN;
                    idx_next    = '0;
                    remain_next = '0;
                end else begin
                    result.valid = 1'b1;
                    result.kind  = KIND_DROP;
                    result.data  = in_byte;
                end
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg  <= PH_HUNT;
            idx_reg    <= '0;
            remain_reg <= '0;
        end else if (step) begin
            phase_reg  <= phase_next;
            idx_reg    <= idx_next;
            remain_reg <= remain_next;
        end
    end

endmodule

// File: sv/magic_length_deframer.sv
// Magic-byte, length-prefixed message deframer: top level.
//
// Takes one received byte per cycle. While hunting, any byte other than the
// magic byte (register 0, reset 'M') comes out as a discarded result; the
// magic byte opens a header of LENGTH_BYTES big-endian length bytes, then
// that many payload bytes pass out, the last with tlast. A zero length gives
// one empty-message result with tlast. m_tuser carries the kind (0 payload,
// 1 empty, 2 discarded). Sustained rate is one byte per cycle: each byte is
// handled in the cycle it is accepted and the result lands in a single
// output register, so s_tready drops only while that register holds a
// result that the sink has not taken. Write the magic byte only while idle.
module magic_length_deframer
    import mld_pkg::*;
(
    input  logic        aclk,
    input  logic        aresetn,
    // input stream
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,   // [7:0] in_byte
    // result stream
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [7:0]  m_tdata,   // [7:0] out_byte
    output logic [1:0]  m_tuser,   // [1:0] kind
    output logic        m_tlast,
    // configuration
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);

    logic        magic_sel;
    logic [7:0]  magic_byte_reg;
    logic        cfg_wr;
    logic        in_take;
    mld_result_t core_res;

    logic        out_valid_reg, out_valid_next;
    logic [1:0]  out_kind_reg;
    logic [7:0]  out_data_reg;
    logic        out_last_reg;

    // APB register
    assign pready    = 1'b1;
    assign magic_sel = (paddr[2] == ADDR_MAGIC[2]);
    assign cfg_wr    = psel && penable && pwrite && magic_sel;
    assign prdata    = magic_sel ? {24'd0, magic_byte_reg} : 32'd0;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            magic_byte_reg <= MAGIC_RESET;
        end else if (cfg_wr) begin
            magic_byte_reg <= pwdata[7:0];
        end
    end

    // Accept while the output register is empty or being drained
    assign s_tready = !out_valid_reg || m_tready;
    assign in_take  = s_tvalid && s_tready;

    mld_core u_core (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .step       (in_take),
        .in_byte    (s_tdata),
        .magic_byte (magic_byte_reg),
        .result     (core_res)
    );

    always_comb begin
        out_valid_next = out_valid_reg;
        if (m_tready) begin
            out_valid_next = 1'b0;
        end
        if (in_take && core_res.valid) begin
            out_valid_next = 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else begin
            out_valid_reg <= out_valid_next;
        end
    end

    // Payload of the result register
    always_ff @(posedge aclk) begin
        if (in_take && core_res.valid) begin
            out_kind_reg <= core_res.kind;
            out_data_reg <= core_res.data;
            out_last_reg <= core_res.last;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_data_reg;
    assign m_tuser  = out_kind_reg;
    assign m_tlast  = out_last_reg;

`ifndef NO_ASSERTIONS
    // A held result must block new input
    a_stall_blocks_input: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && !m_tready) |-> !s_tready)
        else $error("input accepted while result stalled");

    a_kind_legal: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> (m_tuser == KIND_DATA || m_tuser == KIND_EMPTY || m_tuser == KIND_DROP))
        else $error("illegal result kind");

    a_drop_not_last: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && m_tuser == KIND_DROP) |-> !m_tlast)
        else $error("discarded byte marked last");

    a_empty_shape: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && m_tuser == KIND_EMPTY) |-> (m_tlast && m_tdata == 8'd0))
        else $error("empty message result malformed");
`endif

endmodule

// File: sim/tb.sv
// Self-checking testbench for the magic-byte, length-prefixed message deframer.
`timescale 1ns / 100ps

module tb;
    import mld_pkg::*;

    localparam time         HALF_PERIOD = 5ns;
    localparam int unsigned CYCLE_LIMIT = 400000;
    localparam int unsigned LONG_HOLD   = 200;
    localparam int unsigned MAX_LINES   = 40;
    localparam logic [2:0]  ADDR_SPARE  = 3'd4;   // register index 1: unused

    typedef struct packed {
        logic [1:0] kind;
        logic [7:0] data;
        logic       last;
    } deframed_t;

    logic        aclk     = 1'b0;
    logic        aresetn  = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [7:0]  s_tdata  = 8'h00;
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [7:0]  m_tdata;
    logic [1:0]  m_tuser;
    logic        m_tlast;
    logic        psel     = 1'b0;
    logic        penable  = 1'b0;
    logic        pwrite   = 1'b0;
    logic [2:0]  paddr    = '0;
    logic [31:0] pwdata   = '0;
    logic [31:0] prdata;
    logic        pready;

    // predictor state
    logic [1:0]          frame_phase = PH_HUNT;
    int unsigned         hdr_count   = 0;
    logic [REMAIN_W-1:0] bytes_left  = '0;
    logic [7:0]          magic_val   = MAGIC_RESET;

    logic [7:0]  stream_bytes[$];
    deframed_t   pending_results[$];
    int unsigned bytes_loaded  = 0;
    int unsigned bytes_taken   = 0;
    int unsigned fail_count    = 0;
    int unsigned cycle_count   = 0;
    int unsigned n_payload     = 0;
    int unsigned n_empty       = 0;
    int unsigned n_dropped     = 0;
    int unsigned n_settings    = 0;
    int unsigned tx_gap        = 0;
    int unsigned rx_wait       = 0;
    int unsigned hold_left     = 0;
    logic        hold_arm      = 1'b0;
    bit          tx_idle_on    = 1'b1;
    bit          rx_idle_on    = 1'b1;

    magic_length_deframer DUT (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .m_tlast  (m_tlast),
        .psel     (psel),
        .penable  (penable),
        .pwrite   (pwrite),
        .paddr    (paddr),
        .pwdata   (pwdata),
        .prdata   (prdata),
        .pready   (pready)
    );

    always #(HALF_PERIOD) aclk = ~aclk;

    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("Timeout after %0d cycles, %0d results outstanding",
                     cycle_count, pending_results.size());
            $display("Regression FAIL");
            $finish;
        end
    end

    task automatic report_mismatch(input string what);
        fail_count++;
        if (fail_count <= MAX_LINES)
            $display("[%0t] mismatch: %s", $realtime, what);
    endtask

    // Advance the deframer state by one accepted byte and queue its result.
    task automatic deframe_byte(input logic [7:0] b);
        deframed_t r;
        bit        emit;
        r    = '0;
        emit = 1'b0;
        case (frame_phase)
            PH_LEN: begin
                bytes_left = {bytes_left[REMAIN_W-9:0], b};
                hdr_count++;
                if (hdr_count >= LENGTH_BYTES) begin
                    hdr_count = 0;
                    if (bytes_left == '0) begin
                        frame_phase = PH_HUNT;
                        r.kind = KIND_EMPTY;
                        r.data = 8'h00;
                        r.last = 1'b1;
                        emit   = 1'b1;
                    end else begin
                        frame_phase = PH_DATA;
                    end
                end
            end
            PH_DATA: begin
                r.kind = KIND_DATA;
                r.data = b;
                r.last = (bytes_left <= 1);
                emit   = 1'b1;
                if (bytes_left != '0)
                    bytes_left = bytes_left - 1;
                if (r.last) begin
                    bytes_left  = '0;
                    frame_phase = PH_HUNT;
                end
            end
            default: begin
                frame_phase = PH_HUNT;
                if (b == magic_val) begin
                    frame_phase = PH_LEN;
                    hdr_count   = 0;
                    bytes_left  = '0;
                end else begin
                    r.kind = KIND_DROP;
                    r.data = b;
                    r.last = 1'b0;
                    emit   = 1'b1;
                end
            end
        endcase
        if (emit)
            pending_results.push_back(r);
    endtask

    // Input side: offer queued bytes with a random gap after each one.
    always @(posedge aclk) begin
        if (!aresetn) begin
            s_tvalid <= 1'b0;
            s_tdata  <= 8'h00;
            tx_gap   <= 0;
        end else begin
            if (s_tvalid && s_tready) begin
                deframe_byte(s_tdata);
                bytes_taken++;
            end
            if (!(s_tvalid && !s_tready)) begin
                if (tx_gap != 0) begin
                    s_tvalid <= 1'b0;
                    tx_gap   <= tx_gap - 1;
                end else if (stream_bytes.size() != 0) begin
                    s_tvalid <= 1'b1;
                    s_tdata  <= stream_bytes.pop_front();
                    tx_gap   <= tx_idle_on ? $urandom_range(0, 4) : 0;
                end else begin
                    s_tvalid <= 1'b0;
                end
            end
        end
    end

    // Long sink hold-off, counted here so the input keeps offering meanwhile.
    always @(posedge aclk) begin
        if (hold_arm)
            hold_left <= LONG_HOLD;
        else if (hold_left != 0)
            hold_left <= hold_left - 1;
    end

    // Result side: check each accepted result, then stall at random.
    always @(posedge aclk) begin
        deframed_t   want;
        int unsigned w;
        if (!aresetn) begin
            m_tready <= 1'b0;
            rx_wait  <= 0;
        end else begin
            if (m_tvalid && m_tready) begin
                case (m_tuser)
                    KIND_DATA:  n_payload++;
                    KIND_EMPTY: n_empty++;
                    default:    n_dropped++;
                endcase
                if (pending_results.size() == 0) begin
                    report_mismatch($sformatf("unexpected result kind %0d byte %02h last %0d",
                                              m_tuser, m_tdata, m_tlast));
                end else begin
                    want = pending_results.pop_front();
                    if (m_tuser !== want.kind)
                        report_mismatch($sformatf("kind %0d, want %0d", m_tuser, want.kind));
                    if (m_tdata !== want.data)
                        report_mismatch($sformatf("byte %02h, want %02h", m_tdata, want.data));
                    if (m_tlast !== want.last)
                        report_mismatch($sformatf("last %0d, want %0d", m_tlast, want.last));
                end
            end
            if (hold_left != 0) begin
                m_tready <= 1'b0;
            end else if (m_tvalid && m_tready) begin
                w = rx_idle_on ? $urandom_range(0, 4) : 0;
                // a nonzero w drops ready until rx_wait runs out; zero keeps it high
                rx_wait  <= (w != 0) ? w - 1 : 0;
                m_tready <= (w == 0);
            end else if (!m_tready) begin
                if (rx_wait != 0)
                    rx_wait <= rx_wait - 1;
                else
                    m_tready <= 1'b1;
            end
        end
    end

    task automatic push_byte(input logic [7:0] b);
        stream_bytes.push_back(b);
        bytes_loaded++;
    endtask

    task automatic push_message(input int unsigned len);
        logic [63:0] len64;
        len64 = len;
        push_byte(magic_val);
        for (int i = LENGTH_BYTES - 1; i >= 0; i--)
            push_byte(len64[8*i +: 8]);
        repeat (len)
            push_byte($urandom_range(0, 255));
    endtask

    // Mostly well-formed messages, with stray non-magic bytes in between.
    task automatic push_traffic(input int unsigned n_bytes);
        int unsigned start;
        int unsigned pick;
        logic [7:0]  junk;
        start = bytes_loaded;
        while (bytes_loaded - start < n_bytes) begin
            pick = $urandom_range(0, 99);
            if (pick < 20) begin
                repeat ($urandom_range(1, 3)) begin
                    do
                        junk = $urandom_range(0, 255);
                    while (junk == magic_val);
                    push_byte(junk);
                end
            end else if (pick < 30) begin
                push_message(0);
            end else if (pick < 33) begin
                push_message($urandom_range(64, 300));
            end else begin
                push_message($urandom_range(1, 12));
            end
        end
    endtask

    // Hold the sender until every byte is in and every result is out.
    task automatic wait_drained;
        while (bytes_taken != bytes_loaded || pending_results.size() != 0)
            @(posedge aclk);
        repeat (4) @(posedge aclk);
    endtask

    task automatic apb_write(input logic [2:0] addr, input logic [31:0] val);
        @(posedge aclk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= addr;
        pwdata  <= val;
        @(posedge aclk);
        penable <= 1'b1;
        @(posedge aclk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        if (addr == ADDR_MAGIC) begin
            magic_val = val[7:0];
            n_settings++;
        end
    endtask

    task automatic check_magic_readback;
        logic [31:0] got;
        @(posedge aclk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        paddr   <= ADDR_MAGIC;
        @(posedge aclk);
        penable <= 1'b1;
        @(posedge aclk);
        got = prdata;
        psel    <= 1'b0;
        penable <= 1'b0;
        if (got !== {24'h0, magic_val})
            report_mismatch($sformatf("magic readback %08h, want %02h", got, magic_val));
    endtask

    task automatic set_magic(input logic [31:0] val);
        apb_write(ADDR_MAGIC, val);
        check_magic_readback();
    endtask

    initial begin
        repeat (9) @(posedge aclk);
        aresetn <= 1'b1;
        check_magic_readback();

        // directed: stray bytes, empty message, magic inside payload, extremes
        push_byte(8'h00);
        push_byte(8'hFF);
        push_byte(MAGIC_RESET - 8'd1);
        push_byte(MAGIC_RESET + 8'd1);
        push_message(0);
        push_byte(magic_val);
        push_byte(8'h00); push_byte(8'h00); push_byte(8'h00); push_byte(8'h01);
        push_byte(magic_val);
        push_byte(magic_val);
        push_byte(8'h00); push_byte(8'h00); push_byte(8'h00); push_byte(8'h02);
        push_byte(8'h00); push_byte(8'hFF);
        wait_drained();

        // change the magic byte in the middle of a payload
        push_byte(magic_val);
        push_byte(8'h00); push_byte(8'h00); push_byte(8'h00); push_byte(8'h03);
        push_byte(8'h11);
        wait_drained();
        set_magic(32'h0000_005A);
        push_byte(8'h5A);
        push_byte(MAGIC_RESET);
        push_byte(MAGIC_RESET);
        push_message(2);
        wait_drained();

        // upper write data bits are dropped; the spare address is ignored
        set_magic(32'hFFFF_FF00);
        apb_write(ADDR_SPARE, 32'hFFFF_FFFF);
        check_magic_readback();
        push_traffic(220);
        wait_drained();

        set_magic(32'h0000_00FF);
        tx_idle_on = 1'b0;
        push_traffic(220);
        wait_drained();

        set_magic($urandom_range(1, 254));
        tx_idle_on = 1'b1;
        rx_idle_on = 1'b0;
        push_traffic(220);
        wait_drained();

        // long sink stall with the source still pushing
        set_magic(MAGIC_RESET);
        rx_idle_on = 1'b1;
        push_traffic(160);
        @(posedge aclk);
        hold_arm <= 1'b1;
        @(posedge aclk);
        hold_arm <= 1'b0;
        wait_drained();

        tx_idle_on = 1'b0;
        rx_idle_on = 1'b0;
        push_traffic(120);
        wait_drained();

        set_magic($urandom_range(0, 255));
        tx_idle_on = 1'b1;
        rx_idle_on = 1'b1;
        push_traffic(220);

        // near-maximum length: the payload runs past the end of the stimulus
        push_byte(magic_val);
        push_byte(8'hFF); push_byte(8'hFF); push_byte(8'hFF); push_byte(8'hFE);
        repeat (40) push_byte($urandom_range(0, 255));
        wait_drained();
        repeat (10) @(posedge aclk);

        $display("Sent %0d bytes under %0d magic settings; checked %0d payload, %0d empty,",
                 bytes_taken, n_settings + 1, n_payload, n_empty);
        $display("%0d discarded results with random source gaps and sink stalls, %0d errors",
                 n_dropped, fail_count);
        if (fail_count == 0)
            $display("Regression PASS");
        else
            $display("Regression FAIL");
        $finish;
    end

endmodule

// File: magic_length_deframer.f
sv/mld_pkg.sv
sv/mld_core.sv
sv/magic_length_deframer.sv
sim/tb.sv
